// File: hw/rtl/six_axis_tare_offset_removal_defines.svh
// Assertion macros shared by the checker of the six-axis tare offset removal block
`ifndef SIX_AXIS_TARE_OFFSET_REMOVAL_DEFINES_SVH
`define SIX_AXIS_TARE_OFFSET_REMOVAL_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TARE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TARE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked also while reset is held
`define TARE_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tare_pkg.sv
// Shared types and constants of the six-axis tare offset removal block
package tare_pkg;

  localparam int FIELD_W = 32;
  localparam int FIELDS  = 6;
  localparam int CNT_W   = 16;

  localparam logic [CNT_W-1:0]   TARE_RESET = 16'd200;
  localparam logic [FIELD_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] SAT_MIN    = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_TARE,
    ST_DIV,
    ST_RUN
  } tare_state_t;

  typedef struct packed {
    logic             acc_en;
    logic             div_start;
    logic [CNT_W-1:0] divisor;
  } lane_ctrl_t;

endpackage

// File: hw/rtl/tare_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle
module tare_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;

  logic [DEN_W:0]   shifted;
  logic             fits;
  logic [DEN_W:0]   diff;

  assign shifted = {rem_r, q_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Work on the magnitude, restore the sign at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      den_r <= den;
      rem_r <= '0;
      q_r   <= num[NUM_W-1] ? (~num + 1'b1) : num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? $signed(~q_r + 1'b1) : $signed(q_r);

endmodule

// File: hw/rtl/tare_lane.sv
// One channel: tare accumulator, offset divider and saturating offset subtraction
module tare_lane #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tare_pkg::lane_ctrl_t      ctrl,
  input  logic [SAMPLE_WIDTH-1:0]   sample,
  output logic                      done,
  output logic [tare_pkg::FIELD_W-1:0] net
);
  import tare_pkg::*;

  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
  localparam int DIFF_W = FIELD_W + 1;

  logic signed [SAMPLE_WIDTH-1:0] sample_s;
  logic signed [SUM_W-1:0]        sum_r;
  logic signed [SAMPLE_WIDTH-1:0] offset_r;
  logic signed [SUM_W-1:0]        quo;
  logic                           div_done;
  logic signed [DIFF_W-1:0]       diff;

  assign sample_s = $signed(sample);

  tare_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.div_start),
    .num   (sum_r),
    .den   (ctrl.divisor),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      offset_r <= '0;
    end else begin
      if (ctrl.acc_en) begin
        sum_r <= sum_r + SUM_W'(sample_s);
      end
      if (div_done) begin
        offset_r <= quo[SAMPLE_WIDTH-1:0];
      end
    end
  end

  assign done = div_done;
  assign diff = DIFF_W'(sample_s) - DIFF_W'(offset_r);

  // Clamp when the top two bits disagree
  always_comb begin
    if (diff[DIFF_W-1] != diff[DIFF_W-2]) begin
      net = diff[DIFF_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      net = diff[FIELD_W-1:0];
    end
  end

endmodule

// File: hw/rtl/six_axis_tare_offset_removal.sv
// Six-axis tare offset removal: tare control, channel lanes and output buffer
//
// Input stream in_*: one force/torque sample per transaction; in_tuser is the
// frame-ok flag, in_tdata carries the six 32-bit channels. Transactions with
// in_tuser low are taken and dropped. Output stream out_*: six net values per
// transaction. cfg_* writes the tare length (16 bits); the user must write it
// only while the block is idle; the block does not enforce this. The first
// tare-length good samples are summed per channel and produce no output. The
// last of them starts the per-lane serial dividers; in_tready then stays low
// until the one-bit-per-cycle dividers finish the 48-bit sum. Then each good
// sample's result goes to the output register, or to the skid entry while
// it is held, one transaction per cycle with an entry free. The two-entry
// buffer lets the input keep moving while one result waits; with both entries
// full in_tready drops until the receiver takes one. Reset clears the sums,
// offsets, tare count and output buffer, and restores the tare length to 200.
module six_axis_tare_offset_removal #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int CHANNELS     = 6
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  input  logic [tare_pkg::FIELDS*tare_pkg::FIELD_W-1:0] in_tdata,
  // frame_ok
  input  logic                                         in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // net_force_x, net_force_y, net_force_z, net_torque_x, net_torque_y, net_torque_z
  output logic [tare_pkg::FIELDS*tare_pkg::FIELD_W-1:0] out_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [tare_pkg::CNT_W-1:0]                   cfg_data
);
  import tare_pkg::*;

  localparam int DATA_W = FIELDS * FIELD_W;

  tare_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] tare_samples_r;
  logic             start_r, start_nxt;
  logic [CNT_W-1:0] count_inc;
  logic             good;
  logic             acc_en;
  logic             push;
  logic             pop;
  lane_ctrl_t       ctrl;
  logic [CHANNELS-1:0] lane_done;
  logic [DATA_W-1:0]   net_all;

  logic              out_valid_r;
  logic              skid_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] skid_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_TARE) || (state_r == ST_RUN && !skid_valid_r);
  assign good      = in_tvalid && in_tready && in_tuser;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    start_nxt = 1'b0;
    acc_en    = 1'b0;
    push      = 1'b0;
    case (state_r)
      ST_TARE: begin
        if (good) begin
          acc_en    = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= tare_samples_r || count_inc == '0) begin
            state_nxt = ST_DIV;
            start_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (&lane_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        push = good;
      end
      default: begin
        state_nxt = ST_TARE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_TARE;
      count_r        <= '0;
      start_r        <= 1'b0;
      tare_samples_r <= TARE_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
      if (cfg_valid && cfg_ready) begin
        tare_samples_r <= cfg_data;
      end
    end
  end

  // Divide by the count of samples actually summed
  assign ctrl.acc_en    = acc_en;
  assign ctrl.div_start = start_r;
  assign ctrl.divisor   = count_r;

  for (genvar c = 0; c < FIELDS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      tare_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_tdata[c*FIELD_W +: SAMPLE_WIDTH]),
        .done   (lane_done[c]),
        .net    (net_all[c*FIELD_W +: FIELD_W])
      );
    end else begin : g_unused
      assign net_all[c*FIELD_W +: FIELD_W] = '0;
    end
  end

  // Output register with one skid entry
  assign pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= net_all;
      end else begin
        out_data_r <= net_all;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/tare_checker.sv
// Port-level checker for the six-axis tare offset removal block, with its bind
`include "six_axis_tare_offset_removal_defines.svh"

module tare_checker (
  input logic                                         clk,
  input logic                                         rst_n,
  input logic                                         in_tvalid,
  input logic                                         in_tready,
  input logic                                         in_tuser,
  input logic                                         out_tvalid,
  input logic                                         out_tready,
  input logic [tare_pkg::FIELDS*tare_pkg::FIELD_W-1:0] out_tdata
);

  // A stalled result stays and keeps its data
  `TARE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // A new result needs a good sample taken the cycle before
  `TARE_ASSERT_NOW(a_out_cause, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tuser), "result without a good sample")

  // Input back-pressure only follows a good sample
  `TARE_ASSERT_NOW(a_ready_drop, $fell(in_tready), $past(in_tvalid && in_tready && in_tuser), "in_tready dropped without cause")

  // Reset empties the output
  `TARE_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result present after reset")

endmodule

bind six_axis_tare_offset_removal tare_checker u_tare_checker (.*);
